[src/iea_pkg.sv]
package iea_pkg;

  localparam logic [4:0] BS_LAST  = 5'd23;
  localparam logic [4:0] TX_LAST  = 5'd18;
  localparam logic [4:0] BS_ORD_LO = 5'd3;
  localparam logic [4:0] BS_ORD_HI = 5'd15;
  localparam int unsigned SB_UNITS = 16;

  localparam logic [1:0] CFG_SHIFT_X = 2'd0;
  localparam logic [1:0] CFG_SHIFT_Y = 2'd1;

  typedef struct packed {
    logic [4:0] block_size;
    logic [2:0] row_in_sb;
    logic [2:0] col_in_sb;
    logic       top_present;
    logic       right_present;
    logic       left_present;
    logic       bottom_present;
    logic [4:0] transform_size;
    logic [4:0] unit_row;
    logic [4:0] unit_col;
    logic       is_chroma;
  } item_t;

  typedef struct packed {
    logic       bs_bad;
    logic       tx_bad;
    logic       has_ord;
    logic [2:0] wl;
    logic [2:0] hl;
    logic [3:0] row;
    logic [3:0] col;
    logic       tr_en;
    logic       bl_en;
    logic       tr_fit;
    logic       bl_fit;
    logic       y_zero;
    logic       sy;
    logic [4:0] y;
    logic [4:0] cnt_h;
  } s1_t;

  typedef struct packed {
    logic bs_bad;
    logic tx_bad;
    logic has_ord;
    logic tr_en;
    logic bl_en;
    logic tr_fit;
    logic bl_fit;
    logic y_zero;
    logic row_zero;
    logic col_zero;
    logic tr_edge;
    logic bl_edge;
    logic bl_col0;
    logic tr_ord;
    logic bl_ord;
  } s2_t;

  typedef struct packed {
    logic tr;
    logic bl;
    logic miss;
  } result_t;

  function automatic logic [2:0] bw_log2(input logic [4:0] bs);
    logic [2:0] v;
    unique case (bs)
      5'd0, 5'd1, 5'd16:         v = 3'd0;
      5'd2, 5'd3, 5'd4, 5'd18:   v = 3'd1;
      5'd5, 5'd6, 5'd7, 5'd20:   v = 3'd2;
      5'd8, 5'd9, 5'd10, 5'd19,
      5'd22, 5'd17:              v = (bs == 5'd17) ? 3'd2 : 3'd3;
      5'd11, 5'd12, 5'd13, 5'd21: v = 3'd4;
      5'd14, 5'd15, 5'd23:       v = 3'd5;
      default:                   v = 3'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] bh_log2(input logic [4:0] bs);
    logic [2:0] v;
    unique case (bs)
      5'd0, 5'd2, 5'd17:          v = 3'd0;
      5'd1, 5'd3, 5'd5, 5'd19:    v = 3'd1;
      5'd4, 5'd6, 5'd8, 5'd16,
      5'd21:                      v = 3'd2;
      5'd7, 5'd9, 5'd11, 5'd18,
      5'd23:                      v = 3'd3;
      5'd10, 5'd12, 5'd14, 5'd20: v = 3'd4;
      5'd13, 5'd15, 5'd22:        v = 3'd5;
      default:                    v = 3'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] tx_w(input logic [4:0] tx);
    logic [4:0] v;
    unique case (tx)
      5'd0, 5'd5, 5'd13:          v = 5'd1;
      5'd1, 5'd6, 5'd7, 5'd15:    v = 5'd2;
      5'd2, 5'd8, 5'd9, 5'd14,
      5'd17:                      v = 5'd4;
      5'd3, 5'd10, 5'd11, 5'd16:  v = 5'd8;
      5'd4, 5'd12, 5'd18:         v = 5'd16;
      default:                    v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] tx_h(input logic [4:0] tx);
    logic [4:0] v;
    unique case (tx)
      5'd0, 5'd6, 5'd14:          v = 5'd1;
      5'd1, 5'd5, 5'd8, 5'd16:    v = 5'd2;
      5'd2, 5'd7, 5'd10, 5'd13,
      5'd18:                      v = 5'd4;
      5'd3, 5'd9, 5'd12, 5'd15:   v = 5'd8;
      5'd4, 5'd11, 5'd17:         v = 5'd16;
      default:                    v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] zorder(input logic [4:0] r, input logic [4:0] c);
    logic [9:0] m;
    m = '0;
    for (int i = 0; i < 5; i++) begin
      m[2*i]   = c[i];
      m[2*i+1] = r[i];
    end
    return m;
  endfunction

  function automatic logic [11:0] code_order(input logic [2:0] wl, input logic [2:0] hl,
                                              input logic [4:0] r, input logic [4:0] c);
    logic [11:0] v;
    if (wl > hl) begin
      v = {1'b0, zorder(r >> 1, c), r[0]};
    end else if (hl > wl) begin
      v = {1'b0, zorder(r, c >> 1), c[0]};
    end else begin
      v = {2'b00, zorder(r, c)};
    end
    return v;
  endfunction

endpackage

[src/intra_edge_availability.sv]
// An accepted item is registered by each stage in turn before it reaches the result channel.
// One item per cycle unless stalled; three register stages (decode, coding order, decide).
// A stalled result holds the output stage; earlier stages keep filling until all are full.
// Reset clears all stage valid bits and sets both chroma shifts to 1.
module intra_edge_availability (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [4:0] block_size,
  input  logic [2:0] row_in_sb,
  input  logic [2:0] col_in_sb,
  input  logic       top_present,
  input  logic       right_present,
  input  logic       left_present,
  input  logic       bottom_present,
  input  logic [4:0] transform_size,
  input  logic [4:0] unit_row,
  input  logic [4:0] unit_col,
  input  logic       is_chroma,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       top_right_ok,
  output logic       bottom_left_ok,
  output logic       order_missing,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  logic             shift_x;
  logic             shift_y;
  iea_pkg::item_t   item;
  iea_pkg::s1_t     s1_data;
  iea_pkg::s2_t     s2_data;
  iea_pkg::result_t res;
  logic             s1_ready;
  logic             s1_valid;
  logic             s2_ready;
  logic             s2_valid;
  logic             s3_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x <= 1'b1;
      shift_y <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iea_pkg::CFG_SHIFT_X: shift_x <= cfg_data;
        iea_pkg::CFG_SHIFT_Y: shift_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item = {block_size, row_in_sb, col_in_sb, top_present, right_present,
                 left_present, bottom_present, transform_size, unit_row, unit_col,
                 is_chroma};

  iea_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .item      (item),
    .shift_x   (shift_x),
    .shift_y   (shift_y),
    .nxt_ready (s2_ready),
    .ready     (s1_ready),
    .valid     (s1_valid),
    .data      (s1_data)
  );

  iea_order u_order (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .nxt_ready (s3_ready),
    .ready     (s2_ready),
    .valid     (s2_valid),
    .data      (s2_data)
  );

  iea_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_data  (s2_data),
    .stall    (result_stall),
    .ready    (s3_ready),
    .valid    (result_valid),
    .data     (res)
  );

  assign item_stall     = !s1_ready;
  assign top_right_ok   = res.tr;
  assign bottom_left_ok = res.bl;
  assign order_missing  = res.miss;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall == (s1_valid && s2_valid && result_valid && result_stall))
    else $error("input stall does not match a full, stalled pipeline");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> s2_valid)
    else $error("item lost between decode and order stages");

  a_miss_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && top_right_ok && bottom_left_ok |-> !order_missing)
    else $error("missing order flagged with both edges available");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !s1_valid && !s2_valid)
    else $error("stage valid set after reset");

endmodule

[src/iea_decode.sv]
module iea_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  iea_pkg::item_t  item,
  input  logic            shift_x,
  input  logic            shift_y,
  input  logic            nxt_ready,
  output logic            ready,
  output logic            valid,
  output iea_pkg::s1_t    data
);

  iea_pkg::s1_t data_next;
  logic [2:0]   wl;
  logic [2:0]   hl;
  logic [4:0]   cnt_w;
  logic [4:0]   cnt_h;
  logic         sx;
  logic         sy;
  logic [5:0]   pbw_raw;
  logic [5:0]   pbh_raw;
  logic [5:0]   pbw;
  logic [5:0]   pbh;

  assign wl      = iea_pkg::bw_log2(item.block_size);
  assign hl      = iea_pkg::bh_log2(item.block_size);
  assign cnt_w   = iea_pkg::tx_w(item.transform_size);
  assign cnt_h   = iea_pkg::tx_h(item.transform_size);
  assign sx      = item.is_chroma & shift_x;
  assign sy      = item.is_chroma & shift_y;
  assign pbw_raw = (6'd1 << wl) >> sx;
  assign pbh_raw = (6'd1 << hl) >> sy;
  assign pbw     = (pbw_raw == 6'd0) ? 6'd1 : pbw_raw;
  assign pbh     = (pbh_raw == 6'd0) ? 6'd1 : pbh_raw;

  always_comb begin
    data_next.bs_bad  = item.block_size > iea_pkg::BS_LAST;
    data_next.tx_bad  = item.transform_size > iea_pkg::TX_LAST;
    data_next.has_ord = (item.block_size >= iea_pkg::BS_ORD_LO) &&
                        (item.block_size <= iea_pkg::BS_ORD_HI);
    data_next.wl      = wl;
    data_next.hl      = hl;
    data_next.row     = {item.row_in_sb, 1'b0} >> hl;
    data_next.col     = {item.col_in_sb, 1'b0} >> wl;
    data_next.tr_en   = item.top_present & item.right_present;
    data_next.bl_en   = item.left_present & item.bottom_present & (item.unit_col == 5'd0);
    data_next.tr_fit  = ({1'b0, item.unit_col} + {1'b0, cnt_w}) < pbw;
    data_next.bl_fit  = ({1'b0, item.unit_row} + {1'b0, cnt_h}) < pbh;
    data_next.y_zero  = item.unit_row == 5'd0;
    data_next.sy      = sy;
    data_next.y       = item.unit_row;
    data_next.cnt_h   = cnt_h;
  end

  assign ready = !valid || nxt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule

[src/iea_order.sv]
module iea_order (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  iea_pkg::s1_t  in_data,
  input  logic          nxt_ready,
  output logic          ready,
  output logic          valid,
  output iea_pkg::s2_t  data
);

  iea_pkg::s2_t data_next;
  logic [4:0]   row5;
  logic [4:0]   col5;
  logic [4:0]   row_p1;
  logic [4:0]   col_p1;
  logic [4:0]   row_m1;
  logic [4:0]   col_m1;
  logic [9:0]   row_px;
  logic [10:0]  bl_sum;
  logic [10:0]  bl_lim;
  logic [11:0]  ord_cur;
  logic [11:0]  ord_tr;
  logic [11:0]  ord_bl;

  assign row5    = {1'b0, in_data.row};
  assign col5    = {1'b0, in_data.col};
  assign row_p1  = row5 + 5'd1;
  assign col_p1  = col5 + 5'd1;
  assign row_m1  = row5 - 5'd1;
  assign col_m1  = col5 - 5'd1;
  assign row_px  = (10'(in_data.row) << in_data.hl) >> in_data.sy;
  assign bl_sum  = 11'(row_px) + 11'(in_data.y) + 11'(in_data.cnt_h);
  assign bl_lim  = 11'(iea_pkg::SB_UNITS) >> in_data.sy;
  assign ord_cur = iea_pkg::code_order(in_data.wl, in_data.hl, row5, col5);
  assign ord_tr  = iea_pkg::code_order(in_data.wl, in_data.hl, row_m1, col_p1);
  assign ord_bl  = iea_pkg::code_order(in_data.wl, in_data.hl, row_p1, col_m1);

  always_comb begin
    data_next.bs_bad   = in_data.bs_bad;
    data_next.tx_bad   = in_data.tx_bad;
    data_next.has_ord  = in_data.has_ord;
    data_next.tr_en    = in_data.tr_en;
    data_next.bl_en    = in_data.bl_en;
    data_next.tr_fit   = in_data.tr_fit;
    data_next.bl_fit   = in_data.bl_fit;
    data_next.y_zero   = in_data.y_zero;
    data_next.row_zero = in_data.row == 4'd0;
    data_next.col_zero = in_data.col == 4'd0;
    data_next.tr_edge  = (10'(col_p1) << in_data.wl) >= 10'(iea_pkg::SB_UNITS);
    data_next.bl_edge  = (10'(row_p1) << in_data.hl) >= 10'(iea_pkg::SB_UNITS);
    data_next.bl_col0  = bl_sum < bl_lim;
    data_next.tr_ord   = ord_tr < ord_cur;
    data_next.bl_ord   = ord_bl < ord_cur;
  end

  assign ready = !valid || nxt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule

[src/iea_decide.sv]
module iea_decide (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  iea_pkg::s2_t     in_data,
  input  logic             stall,
  output logic             ready,
  output logic             valid,
  output iea_pkg::result_t data
);

  iea_pkg::result_t data_next;

  always_comb begin
    data_next = '0;
    if (in_data.bs_bad) begin
      data_next.miss = 1'b1;
    end else if (!in_data.tx_bad) begin
      if (in_data.tr_en) begin
        if (in_data.tr_fit) begin
          data_next.tr = 1'b1;
        end else if (!in_data.y_zero) begin
          data_next.tr = 1'b0;
        end else if (in_data.row_zero) begin
          data_next.tr = 1'b1;
        end else if (in_data.tr_edge) begin
          data_next.tr = 1'b0;
        end else if (!in_data.has_ord) begin
          data_next.miss = 1'b1;
        end else begin
          data_next.tr = in_data.tr_ord;
        end
      end
      if (in_data.bl_en) begin
        if (in_data.bl_fit) begin
          data_next.bl = 1'b1;
        end else if (in_data.col_zero) begin
          data_next.bl = in_data.bl_col0;
        end else if (in_data.bl_edge) begin
          data_next.bl = 1'b0;
        end else if (!in_data.has_ord) begin
          data_next.miss = 1'b1;
        end else begin
          data_next.bl = in_data.bl_ord;
        end
      end
    end
  end

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule
